// ===== rtl/core/a85enc_pkg.sv =====
// Shared types and constants for the ASCII85 stream encoder.
// No dependencies; imported by every module of the encoder.
`timescale 1ns / 1ps
`default_nettype none

package a85enc_pkg;

    localparam int unsigned A85_BASE   = 85;
    localparam logic [7:0]  A85_OFFSET = 8'd33;

    // floor(v / 85) == (v * A85_RECIP) >> A85_SHIFT for every 32-bit v
    localparam logic [31:0] A85_RECIP  = 32'd3233857729;
    localparam int unsigned A85_SHIFT  = 38;

    localparam logic [7:0]  CHAR_Z     = 8'h7A;
    localparam logic [7:0]  CHAR_TILDE = 8'h7E;
    localparam logic [7:0]  CHAR_GT    = 8'h3E;
    localparam logic [7:0]  CHAR_NL    = 8'h0A;

    localparam logic        OP_DATA    = 1'b0;
    localparam logic        OP_FINISH  = 1'b1;

    // job queue between front and converter
    localparam int unsigned JOBQ_DEPTH = 2;
    localparam int unsigned JOBQ_AW    = $clog2(JOBQ_DEPTH);

    // tuple to convert, as classified by the front
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  ndig;   // digits to emit, 0..5
        logic        zero;   // emit 'z' only
        logic        eod;    // append end marker
    } front_job_t;

    // converted tuple, raw base-85 digits most significant first
    typedef struct packed {
        logic [4:0][6:0] digits;
        logic [2:0]      ndig;
        logic            zero;
        logic            eod;
    } conv_job_t;

    function automatic logic [7:0] eod_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CHAR_TILDE;
            2'd1:    ch = CHAR_GT;
            default: ch = CHAR_NL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/a85enc_front.sv =====
// Front end: takes items, gathers bytes into a tuple, classifies flushes.
// Depends on a85enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a85enc_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic                    op,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    eod_en,
    input  wire logic                    q_full,
    output logic                         q_push,
    output a85enc_pkg::front_job_t       q_job
);
    import a85enc_pkg::*;

    logic [31:0] tuple_reg, tuple_next;
    logic [1:0]  count_reg, count_next;
    logic        accept;
    logic [31:0] shifted;
    logic [31:0] padded;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign shifted = {tuple_reg[23:0], data_byte};

    always_comb
    begin
        case (count_reg)
            2'd1:    padded = {tuple_reg[7:0], 24'd0};
            2'd2:    padded = {tuple_reg[15:0], 16'd0};
            2'd3:    padded = {tuple_reg[23:0], 8'd0};
            default: padded = 32'd0;
        endcase
    end

    always_comb
    begin
        tuple_next  = tuple_reg;
        count_next  = count_reg;
        q_push      = 1'b0;
        q_job.value = shifted;
        q_job.ndig  = 3'd5;
        q_job.zero  = (shifted == 32'd0);
        q_job.eod   = 1'b0;
        if (accept)
        begin
            if (op == OP_DATA)
            begin
                if (count_reg == 2'd3)
                begin
                    q_push     = 1'b1;
                    tuple_next = 32'd0;
                    count_next = 2'd0;
                end
                else
                begin
                    tuple_next = shifted;
                    count_next = count_reg + 2'd1;
                end
            end
            else
            begin
                q_job.value = padded;
                q_job.ndig  = (count_reg == 2'd0) ? 3'd0 : {1'b0, count_reg} + 3'd1;
                q_job.zero  = 1'b0;
                q_job.eod   = eod_en;
                // an empty finish with the marker off produces nothing
                q_push      = (count_reg != 2'd0) || eod_en;
                tuple_next  = 32'd0;
                count_next  = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuple_reg <= 32'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            tuple_reg <= tuple_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/a85enc_jobq.sv =====
// Short job queue between the front end and the converter.
// Depends on a85enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a85enc_jobq (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire a85enc_pkg::front_job_t  wr_job,
    output logic                         full,
    input  wire logic                    rd_en,
    output a85enc_pkg::front_job_t       rd_job,
    output logic                         not_empty
);
    import a85enc_pkg::*;

    front_job_t               slot_reg [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [JOBQ_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [JOBQ_AW:0]         count_reg, count_next;
    logic                     do_wr, do_rd;

    assign full      = (count_reg == (JOBQ_AW+1)'(JOBQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_job    = slot_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/a85enc_conv.sv =====
// Back end converter: base-85 digits by repeated division with one shared
// reciprocal multiplier (multiply step, then reduce step). Depends on a85enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a85enc_conv (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_not_empty,
    input  wire a85enc_pkg::front_job_t  q_job,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output a85enc_pkg::conv_job_t        out_job
);
    import a85enc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    conv_job_t   job_reg, job_next;
    logic [31:0] cur_v_reg, cur_v_next;
    logic [63:0] prod_reg, prod_next;
    logic [2:0]  pos_reg, pos_next;

    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [25:0] quot;
    logic [31:0] quot_x85;
    logic [31:0] rem_full;
    logic        need_conv;

    assign q_pop     = q_not_empty &&
                       ((state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_ready));
    assign out_valid = (state_reg == ST_DONE);
    assign out_job   = job_reg;
    assign need_conv = !q_job.zero && (q_job.ndig != 3'd0);

    assign mul_a    = (state_reg == ST_MUL) ? cur_v_reg : q_job.value;
    assign mul_p    = {32'd0, mul_a} * {32'd0, A85_RECIP};
    assign quot     = prod_reg[63:A85_SHIFT];
    assign quot_x85 = {quot, 6'd0} + {2'd0, quot, 4'd0} + {4'd0, quot, 2'd0} + {6'd0, quot};
    assign rem_full = cur_v_reg - quot_x85;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cur_v_next = cur_v_reg;
        prod_next  = prod_reg;
        pos_next   = pos_reg;

        case (state_reg)
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                job_next.digits[pos_reg] = rem_full[6:0];
                if (pos_reg == 3'd1)
                begin
                    // final quotient is below 85 and is the leading digit
                    job_next.digits[0] = quot[6:0];
                    state_next         = ST_DONE;
                end
                else
                begin
                    cur_v_next = {6'd0, quot};
                    pos_next   = pos_reg - 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // load overlaps the first multiply
        if (q_pop)
        begin
            job_next.ndig = q_job.ndig;
            job_next.zero = q_job.zero;
            job_next.eod  = q_job.eod;
            if (need_conv)
            begin
                cur_v_next = q_job.value;
                prod_next  = mul_p;
                pos_next   = 3'd4;
                state_next = ST_DIV;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        cur_v_reg <= cur_v_next;
        prod_reg  <= prod_next;
        pos_reg   <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/a85enc_emit.sv =====
// Output stage: holds one converted job and hands out its characters one
// per pop. Depends on a85enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a85enc_emit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire a85enc_pkg::conv_job_t   in_job,
    output logic                         empty,
    input  wire logic                    pop,
    output logic [7:0]                   out_char,
    output logic                         last_of_run
);
    import a85enc_pkg::*;

    logic       valid_reg, valid_next;
    conv_job_t  job_reg, job_next;
    logic [2:0] pos_reg, pos_next;

    logic [3:0] total;
    logic [2:0] eod_idx;
    logic [6:0] digit;
    logic       take;
    logic       popped;

    assign empty  = !valid_reg;
    assign popped = pop && valid_reg;

    always_comb
    begin
        if (job_reg.zero)
            total = 4'd1;
        else
            total = {1'b0, job_reg.ndig} + (job_reg.eod ? 4'd3 : 4'd0);
    end

    assign last_of_run = ({1'b0, pos_reg} + 4'd1 == total);
    assign in_ready    = !valid_reg || (popped && last_of_run);
    assign take        = in_valid && in_ready;
    assign eod_idx     = pos_reg - job_reg.ndig;

    always_comb
    begin
        case (pos_reg)
            3'd0:    digit = job_reg.digits[0];
            3'd1:    digit = job_reg.digits[1];
            3'd2:    digit = job_reg.digits[2];
            3'd3:    digit = job_reg.digits[3];
            default: digit = job_reg.digits[4];
        endcase
    end

    always_comb
    begin
        if (job_reg.zero)
            out_char = CHAR_Z;
        else if (pos_reg < job_reg.ndig)
            out_char = {1'b0, digit} + A85_OFFSET;
        else
            out_char = eod_char(eod_idx[1:0]);
    end

    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        pos_next   = pos_reg;
        if (popped)
        begin
            if (last_of_run)
                valid_next = 1'b0;
            else
                pos_next = pos_reg + 3'd1;
        end
        if (take)
        begin
            valid_next = 1'b1;
            job_next   = in_job;
            pos_next   = 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ascii85_stream_encoder_core.sv =====
// Top level of the ASCII85 stream encoder: config register, front end,
// job queue, converter and output stage. Depends on a85enc_pkg and a85enc_* modules.
//
//   channel   direction   handshake          payload
//   input     in          push / full        op, data_byte
//   result    out         empty / pop        out_char, last_of_run
//   config    in          cfg_we             cfg_wdata (eod marker enable)
//
// An item is taken in any cycle the two-entry job queue has room; partial
// bytes only update the tuple. Each non-zero tuple or partial flush goes through
// repeated multiply and reduce steps in the converter on one shared 32x32 multiplier;
// 'z' and marker-only jobs skip them. The front keeps taking bytes while the converter
// works; characters leave at one per cycle while pop is high and empty is low.
// Reset clears the tuple and all valid state and sets the marker enable.
// Front, converter and output stage stall independently.
`timescale 1ns / 1ps
`default_nettype none

module ascii85_stream_encoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       op,
    input  wire logic [7:0] data_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_char,
    output logic            last_of_run,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata
);
    import a85enc_pkg::*;

    logic       eod_en_reg;
    logic       q_full;
    logic       q_push;
    front_job_t front_job;
    front_job_t q_head;
    logic       q_not_empty;
    logic       q_pop;
    logic       conv_valid;
    logic       conv_ready;
    conv_job_t  conv_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eod_en_reg <= 1'b1;
        else if (cfg_we)
            eod_en_reg <= cfg_wdata;
    end

    a85enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .data_byte (data_byte),
        .eod_en    (eod_en_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (front_job)
    );

    a85enc_jobq u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_job    (front_job),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_job    (q_head),
        .not_empty (q_not_empty)
    );

    a85enc_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (q_head),
        .q_pop       (q_pop),
        .out_valid   (conv_valid),
        .out_ready   (conv_ready),
        .out_job     (conv_job)
    );

    a85enc_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (conv_valid),
        .in_ready    (conv_ready),
        .in_job      (conv_job),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== verif/ascii85_stream_encoder_core_tb.sv =====
// Self-checking testbench for ascii85_stream_encoder_core: random and directed byte streams,
// per-character checks against an in-bench ASCII85 encoder model.
// Depends on a85enc_pkg and the encoder RTL.
`timescale 1ns / 1ps

module ascii85_stream_encoder_core_tb;

    import a85enc_pkg::*;

    localparam int DRAIN_CYCLES  = 24;    // idle margin after the expected characters have drained
    localparam int STALL_LIMIT   = 1000;  // cycles with no handshake before giving up
    localparam int HOLD_AT_CHAR  = 140;   // receiver stalls after this many characters
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASE  = 72;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } a85_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } a85_char_t;

    typedef enum int {FILL_ZERO, FILL_RAND, FILL_EXTREME, FILL_SPARSE} fill_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       op = OP_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;

    ascii85_stream_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // encoder model state
    logic [31:0] tuple_acc = '0;
    int unsigned bytes_held = 0;
    logic        eod_en = 1'b1;

    a85_item_t pend_items[$];
    a85_char_t exp_chars[$];
    a85_item_t next_item;

    int  tx_wait = 0;
    int  rx_wait = 0;
    int  hold_cnt = 0;
    int  chars_seen = 0;
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // expected characters for one accepted item
    function automatic void encode_item(input logic op_i, input logic [7:0] byte_i);
        logic [31:0] v;
        logic [7:0]  dig[5];
        a85_char_t   run[7];
        a85_char_t   c;
        int          n;
        int          nd;
        int          i;
        n = 0;
        nd = 0;
        v = '0;
        if (op_i == OP_DATA)
        begin
            tuple_acc = {tuple_acc[23:0], byte_i};
            bytes_held++;
            if (bytes_held == 4)
            begin
                if (tuple_acc == 32'd0)
                begin
                    run[n] = '{ch: CHAR_Z, last: 1'b0};
                    n++;
                end
                else
                begin
                    v = tuple_acc;
                    nd = 5;
                end
                tuple_acc = '0;
                bytes_held = 0;
            end
        end
        else
        begin
            if (bytes_held != 0)
            begin
                v = tuple_acc << (8 * (4 - bytes_held));
                nd = bytes_held + 1;
            end
            tuple_acc = '0;
            bytes_held = 0;
        end
        for (i = 4; i >= 0; i--)
        begin
            dig[i] = 8'(v % A85_BASE) + A85_OFFSET;
            v = v / A85_BASE;
        end
        for (i = 0; i < nd; i++)
        begin
            run[n] = '{ch: dig[i], last: 1'b0};
            n++;
        end
        if (op_i == OP_FINISH && eod_en)
        begin
            run[n] = '{ch: CHAR_TILDE, last: 1'b0};
            run[n + 1] = '{ch: CHAR_GT, last: 1'b0};
            run[n + 2] = '{ch: CHAR_NL, last: 1'b0};
            n += 3;
        end
        for (i = 0; i < n; i++)
        begin
            c = run[i];
            c.last = (i == n - 1);
            exp_chars.push_back(c);
        end
    endfunction

    // driver: offers pending items, random gap between them unless tx_steady is set
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !full)
        begin
            encode_item(op, data_byte);
            tx_wait = tx_steady ? 0 : $urandom_range(0, 7);
            if (tx_wait == 0 && pend_items.size() > 0)
            begin
                next_item = pend_items.pop_front();
                op <= next_item.op;
                data_byte <= next_item.data;
            end
            else
                push <= 1'b0;
        end
        else if (!push)
        begin
            if (tx_wait > 0)
                tx_wait--;
            else if (pend_items.size() > 0)
            begin
                next_item = pend_items.pop_front();
                op <= next_item.op;
                data_byte <= next_item.data;
                push <= 1'b1;
            end
        end
    end

    // monitor: pops characters and checks them in order
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop && !empty)
        begin
            if (exp_chars.size() == 0)
            begin
                $display("%0t: unexpected char expected none actual %h last %b",
                         $time, out_char, last_of_run);
                errors++;
            end
            else
            begin
                if (out_char !== exp_chars[0].ch)
                begin
                    $display("%0t: out_char mismatch expected %h actual %h",
                             $time, exp_chars[0].ch, out_char);
                    errors++;
                end
                if (last_of_run !== exp_chars[0].last)
                begin
                    $display("%0t: last_of_run mismatch expected %b actual %b",
                             $time, exp_chars[0].last, last_of_run);
                    errors++;
                end
                void'(exp_chars.pop_front());
            end
            chars_seen++;
            if (chars_seen == HOLD_AT_CHAR)
            begin
                // long back-pressure so the job queue fills and full rises
                hold_cnt = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
            begin
                rx_wait = rx_steady ? 0 : $urandom_range(0, 7);
                pop <= (rx_wait == 0);
            end
        end
        else if (!pop)
        begin
            if (hold_cnt > 0)
                hold_cnt--;
            else if (rx_wait > 0)
                rx_wait--;
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic add_item(input logic o, input logic [7:0] b);
        a85_item_t it;
        it.op = o;
        it.data = b;
        pend_items.push_back(it);
    endtask

    // mostly complete streams ending in finish, some loose noise items
    task automatic add_random(input int n);
        int    made;
        int    len;
        int    j;
        fill_t fill;
        logic [7:0] b;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 11);
                fill = fill_t'($urandom_range(0, 3));
                for (j = 0; j < len; j++)
                begin
                    case (fill)
                        FILL_ZERO:    b = 8'h00;
                        FILL_RAND:    b = 8'($urandom);
                        FILL_EXTREME: b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                        default:      b = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
                    endcase
                    add_item(OP_DATA, b);
                end
                add_item(OP_FINISH, 8'($urandom));
                made += len + 1;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (j = 0; j < len; j++)
                    add_item(($urandom_range(0, 1) != 0) ? OP_FINISH : OP_DATA, 8'($urandom));
                made += len;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pend_items.size() != 0 || push || exp_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_eod(input logic en);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= en;
        eod_en = en;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // marker on from reset
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        add_item(OP_FINISH, 8'hA5);                      // empty finish, marker only
        repeat (4) add_item(OP_DATA, 8'h00);             // zero tuple
        repeat (4) add_item(OP_DATA, 8'hFF);
        add_item(OP_DATA, 8'h00);
        add_item(OP_DATA, 8'h00);
        add_item(OP_DATA, 8'h00);
        add_item(OP_DATA, 8'h01);
        add_item(OP_DATA, 8'hFF);
        add_item(OP_FINISH, 8'hFF);                      // one byte pending
        add_item(OP_DATA, 8'h00);
        add_item(OP_FINISH, 8'h00);                      // zero partial, no 'z'
        add_item(OP_DATA, 8'h12);
        add_item(OP_DATA, 8'h34);
        add_item(OP_FINISH, 8'h5A);
        add_item(OP_DATA, 8'hAB);
        add_item(OP_DATA, 8'hCD);
        add_item(OP_DATA, 8'hEF);
        add_item(OP_FINISH, 8'h00);
        wait_idle();

        write_eod(1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        add_item(OP_FINISH, 8'h00);                      // empty finish, no output at all
        add_item(OP_DATA, 8'h80);
        add_item(OP_FINISH, 8'h7F);
        repeat (4) add_item(OP_DATA, 8'h00);
        add_item(OP_FINISH, 8'hFF);
        add_random(RANDOM_PHASE);
        wait_idle();

        write_eod(1'b1);
        tx_steady = 1'b1;
        add_random(RANDOM_PHASE);
        wait_idle();

        write_eod(1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b1;
        add_random(RANDOM_PHASE);
        wait_idle();

        write_eod(1'b1);
        rx_steady = 1'b0;
        add_random(RANDOM_PHASE);
        wait_idle();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
